>>> design/xsc_pkg.sv
`timescale 1ns / 1ps
package xsc_pkg;

    localparam int DOUBLE_ROUNDS_DEF = 10;
    localparam int CFG_IDX_W = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_KEY0   = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY1   = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY2   = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY3   = 4'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_NONCE0 = 4'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_NONCE1 = 4'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_NONCE2 = 4'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET = 4'd7;

    localparam logic [31:0] SIGMA0 = 32'h61707865;
    localparam logic [31:0] SIGMA1 = 32'h3320646e;
    localparam logic [31:0] SIGMA2 = 32'h79622d32;
    localparam logic [31:0] SIGMA3 = 32'h6b206574;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       message_end;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       message_end_out;
    } t_out_item;

    // queued item, tagged by the front with the start of a message
    typedef struct packed {
        t_in_item item;
        logic     first;
    } t_q_item;

    typedef struct packed {
        logic [3:0][63:0] key;
        logic [2:0][63:0] nonce;
        logic [63:0]      offset;
    } t_cfg;

    typedef logic [15:0][31:0] t_words;
    typedef logic [7:0][31:0]  t_key;

    typedef enum logic [1:0] {
        BK_RUN,
        BK_SUBKEY,
        BK_BLOCK
    } t_bk_state;

    function automatic logic [31:0] rotl(logic [31:0] x, int s);
        rotl = (x << s) | (x >> (32 - s));
    endfunction

    function automatic t_words quarter(t_words w, int a, int b, int c, int d);
        t_words r;
        r = w;
        r[b] = r[b] ^ rotl(r[a] + r[d], 7);
        r[c] = r[c] ^ rotl(r[b] + r[a], 9);
        r[d] = r[d] ^ rotl(r[c] + r[b], 13);
        r[a] = r[a] ^ rotl(r[d] + r[c], 18);
        quarter = r;
    endfunction

    function automatic t_words salsa_round(t_words w, logic row);
        t_words r;
        r = w;
        if (row) begin
            r = quarter(r, 0, 1, 2, 3);
            r = quarter(r, 5, 6, 7, 4);
            r = quarter(r, 10, 11, 8, 9);
            r = quarter(r, 15, 12, 13, 14);
        end else begin
            r = quarter(r, 0, 4, 8, 12);
            r = quarter(r, 5, 9, 13, 1);
            r = quarter(r, 10, 14, 2, 6);
            r = quarter(r, 15, 3, 7, 11);
        end
        salsa_round = r;
    endfunction

    function automatic t_words load_core(t_key k, logic [63:0] lo, logic [63:0] hi);
        t_words w;
        w[0]  = SIGMA0;
        w[5]  = SIGMA1;
        w[10] = SIGMA2;
        w[15] = SIGMA3;
        for (int i = 0; i < 4; i++) begin
            w[1 + i]  = k[i];
            w[11 + i] = k[4 + i];
        end
        w[6] = lo[31:0];
        w[7] = lo[63:32];
        w[8] = hi[31:0];
        w[9] = hi[63:32];
        load_core = w;
    endfunction

endpackage

>>> design/xsc_front.sv
`timescale 1ns / 1ps
module xsc_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  xsc_pkg::t_in_item  i_in_data,
    output logic               o_head_valid,
    output xsc_pkg::t_q_item   o_head,
    input  logic               i_pop
);
    import xsc_pkg::*;

    t_q_item     r_q [2];
    logic        r_wp, r_rp;
    logic [1:0]  r_cnt;
    logic        r_in_msg;
    logic        push;

    assign o_in_stall   = (r_cnt == 2'd2);
    assign push         = i_in_valid && !o_in_stall;
    assign o_head_valid = (r_cnt != 2'd0);
    assign o_head       = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= '{item: i_in_data, first: !r_in_msg};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp     <= 1'b0;
            r_rp     <= 1'b0;
            r_cnt    <= 2'd0;
            r_in_msg <= 1'b0;
        end else begin
            if (push) begin
                r_wp     <= !r_wp;
                r_in_msg <= !i_in_data.message_end;
            end
            if (i_pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, i_pop};
        end
    end

endmodule

>>> design/xsc_core.sv
`timescale 1ns / 1ps
module xsc_core #(
    parameter int DOUBLE_ROUNDS = xsc_pkg::DOUBLE_ROUNDS_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  xsc_pkg::t_words i_words,
    output logic            o_busy,
    output logic            o_done,
    output xsc_pkg::t_words o_raw,
    output xsc_pkg::t_words o_sum
);
    import xsc_pkg::*;

    localparam int ROUNDS = 2 * DOUBLE_ROUNDS;
    localparam int CW     = $clog2(ROUNDS);

    t_words        r_w, r_init;
    logic [CW-1:0] r_cnt;
    logic          r_busy, r_done;

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_raw  = r_w;

    always_comb begin
        for (int i = 0; i < 16; i++) begin
            o_sum[i] = r_w[i] + r_init[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_w    <= i_words;
            r_init <= i_words;
        end else if (r_busy) begin
            // even steps are column rounds, odd steps row rounds
            r_w <= salsa_round(r_w, r_cnt[0]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(ROUNDS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

endmodule

>>> design/xsc_back.sv
`timescale 1ns / 1ps
module xsc_back #(
    parameter int DOUBLE_ROUNDS = xsc_pkg::DOUBLE_ROUNDS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  xsc_pkg::t_cfg      i_cfg,
    input  logic               i_head_valid,
    input  xsc_pkg::t_q_item   i_head,
    output logic               o_pop,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output xsc_pkg::t_out_item o_out_data
);
    import xsc_pkg::*;

    t_bk_state   r_st, n_st;
    t_key        r_subkey, n_subkey;
    logic [63:0] r_ctr, n_ctr;
    logic [5:0]  r_pos, n_pos;
    logic [15:0][31:0] r_ks;
    logic        r_fresh, n_fresh;
    logic        r_out_valid;
    t_out_item   r_out;

    logic        core_start, core_busy, core_done;
    t_words      core_in, core_raw, core_sum;
    logic        need_sub, emit;
    logic [31:0] ks_word;
    logic [7:0]  ks_byte;

    xsc_core #(.DOUBLE_ROUNDS(DOUBLE_ROUNDS)) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (core_start),
        .i_words (core_in),
        .o_busy  (core_busy),
        .o_done  (core_done),
        .o_raw   (core_raw),
        .o_sum   (core_sum)
    );

    assign need_sub = i_head_valid && i_head.first && !r_fresh;
    assign emit     = (r_st == BK_RUN) && i_head_valid && !need_sub
                      && (!r_out_valid || !i_out_stall);
    assign o_pop    = emit;
    assign ks_word  = r_ks[r_pos[5:2]];
    assign ks_byte  = ks_word[8*r_pos[1:0] +: 8];

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_comb begin
        n_st = r_st;
        unique case (r_st)
            BK_RUN: begin
                if (need_sub) begin
                    n_st = BK_SUBKEY;
                end else if (emit && r_pos == 6'd63) begin
                    n_st = BK_BLOCK;
                end
            end
            BK_SUBKEY: if (core_done) n_st = BK_BLOCK;
            BK_BLOCK:  if (core_done) n_st = BK_RUN;
            default:   n_st = BK_RUN;
        endcase
    end

    always_comb begin
        core_start = 1'b0;
        n_subkey   = r_subkey;
        n_ctr      = r_ctr;
        n_pos      = r_pos;
        n_fresh    = r_fresh;
        core_in    = load_core(r_subkey, i_cfg.nonce[2], r_ctr);
        unique case (r_st)
            BK_RUN: begin
                if (need_sub) begin
                    core_start = 1'b1;
                    n_fresh    = 1'b1;
                    core_in    = load_core(i_cfg.key, i_cfg.nonce[0], i_cfg.nonce[1]);
                end else if (emit) begin
                    n_fresh = 1'b0;
                    n_pos   = r_pos + 6'd1;
                    if (r_pos == 6'd63) begin
                        // advance to the next block even at message end
                        n_ctr      = r_ctr + 64'd1;
                        core_start = 1'b1;
                        core_in    = load_core(r_subkey, i_cfg.nonce[2], n_ctr);
                    end
                end
            end
            BK_SUBKEY: begin
                if (core_done) begin
                    n_subkey = {core_raw[9], core_raw[8], core_raw[7], core_raw[6],
                                core_raw[15], core_raw[10], core_raw[5], core_raw[0]};
                    n_ctr      = {6'd0, i_cfg.offset[63:6]};
                    n_pos      = i_cfg.offset[5:0];
                    core_start = 1'b1;
                    core_in    = load_core(n_subkey, i_cfg.nonce[2], n_ctr);
                end
            end
            BK_BLOCK: ;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_subkey <= n_subkey;
        r_ctr    <= n_ctr;
        r_pos    <= n_pos;
        if (r_st == BK_BLOCK && core_done) begin
            r_ks <= core_sum;
        end
        if (emit) begin
            r_out <= '{out_byte: i_head.item.data_byte ^ ks_byte,
                       message_end_out: i_head.item.message_end};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st        <= BK_RUN;
            r_fresh     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_st    <= n_st;
            r_fresh <= n_fresh;
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        core_start |-> !core_busy)
        else $error("round core restarted while busy");

    a_done_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        core_done |-> (r_st == BK_SUBKEY || r_st == BK_BLOCK))
        else $error("round core finished with no block pending");

    a_emit_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit |-> !core_busy && !core_done)
        else $error("byte sent while keystream block in progress");

endmodule

>>> design/xsalsa20_stream_cipher.sv
`timescale 1ns / 1ps
// XSalsa20 stream cipher, one byte per transfer.
// Input channel: i_in_valid / o_in_stall carry a data byte and a message end
// flag; a transfer happens on a clock edge with valid high and stall low.
// Output channel: o_out_valid / i_out_stall carry the byte XORed with the
// keystream and the copied end flag, in order, one result per input byte.
// Configuration: write key, nonce and start offset through i_cfg_valid with
// i_cfg_index 0..7 (key words 0..3, nonce words 0..2, offset); o_cfg_ready is
// always high, indexes beyond 7 are dropped. Write only while idle.
// A two-entry queue decouples input from the keystream engine.
// A mid-block byte passes through the queue and the output register. The
// first byte of a message also waits for HSalsa20 and one block. Throughput
// is one byte per cycle within a block while the receiver does not stall;
// at each 64-byte boundary bytes wait while the next block is computed by
// the single shared round unit doing one Salsa round per cycle.
// Reset clears the control state; the next byte starts a new message.
// When the receiver stalls, the output byte holds and the queue fills, then
// o_in_stall rises.
module xsalsa20_stream_cipher #(
    parameter int DOUBLE_ROUNDS = xsc_pkg::DOUBLE_ROUNDS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  xsc_pkg::t_in_item                 i_in_data,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output xsc_pkg::t_out_item                o_out_data,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [xsc_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [63:0]                       i_cfg_data
);
    import xsc_pkg::*;

    t_cfg    r_cfg;
    logic    head_valid, pop;
    t_q_item head;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_KEY0:   r_cfg.key[0]   <= i_cfg_data;
                CFG_KEY1:   r_cfg.key[1]   <= i_cfg_data;
                CFG_KEY2:   r_cfg.key[2]   <= i_cfg_data;
                CFG_KEY3:   r_cfg.key[3]   <= i_cfg_data;
                CFG_NONCE0: r_cfg.nonce[0] <= i_cfg_data;
                CFG_NONCE1: r_cfg.nonce[1] <= i_cfg_data;
                CFG_NONCE2: r_cfg.nonce[2] <= i_cfg_data;
                CFG_OFFSET: r_cfg.offset   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    xsc_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_in_data    (i_in_data),
        .o_head_valid (head_valid),
        .o_head       (head),
        .i_pop        (pop)
    );

    xsc_back #(.DOUBLE_ROUNDS(DOUBLE_ROUNDS)) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_head_valid (head_valid),
        .i_head       (head),
        .o_pop        (pop),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_out_data   (o_out_data)
    );

endmodule
